/* rtl/core/rgb2yuv_pkg.sv */
// shared constants, types and helpers of the rgb to yuv 4:2:0 converter
package rgb2yuv_pkg;

	localparam int MAX_SIDE = 4096;
	localparam int CNT_W    = $clog2(MAX_SIDE);
	localparam int SIDE_W   = CNT_W + 1;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W    = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW  = $clog2(FIFO_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [CFG_W-1:0] SIDE_MIN     = 13'd2;
	localparam logic [CFG_W-1:0] SIDE_MAX     = CFG_W'(MAX_SIDE);

	localparam logic [14:0] K_R = 15'd38;
	localparam logic [14:0] K_G = 15'd75;
	localparam logic [14:0] K_B = 15'd15;
	localparam logic signed [15:0] K_U = 16'sd71;
	localparam logic signed [15:0] K_V = 16'sd91;
	localparam logic signed [9:0] CHROMA_OFS = 10'sd128;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic chroma_valid;
		logic frame_end;
	} pix_item_t;

	// clamp a size register to the supported range
	function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] reg_val);
		logic [CFG_W-1:0] v;
		begin
			if (reg_val < SIDE_MIN) begin
				v = SIDE_MIN;
			end else if (reg_val > SIDE_MAX) begin
				v = SIDE_MAX;
			end else begin
				v = reg_val;
			end
			return SIDE_W'(v);
		end
	endfunction

	// floor shift by 7, add offset, saturate to a byte
	function automatic logic [PIX_W-1:0] sat_chroma(input logic signed [15:0] prod);
		logic signed [8:0] sh;
		logic signed [9:0] q;
		begin
			sh = prod[15:7];
			q = {sh[8], sh} + CHROMA_OFS;
			if (q < 0) begin
				return '0;
			end else if (q > 10'sd255) begin
				return '1;
			end else begin
				return q[PIX_W-1:0];
			end
		end
	endfunction

endpackage

/* rtl/core/rgb2yuv_if.sv */
// stream interfaces for pixel input words and yuv result words
interface rgb2yuv_pix_if import rgb2yuv_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgb2yuv_yuv_if import rgb2yuv_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] luma;
	logic chroma_valid;
	logic [PIX_W-1:0] u_out;
	logic [PIX_W-1:0] v_out;
	logic frame_end;

	modport source (output valid, luma, chroma_valid, u_out, v_out, frame_end, input ready);
	modport sink (input valid, luma, chroma_valid, u_out, v_out, frame_end, output ready);
endinterface

/* rtl/core/rgb2yuv_front.sv */
// front end: size registers, position counters and chroma/frame-end tagging
module rgb2yuv_front import rgb2yuv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     in_red,
	input  logic [PIX_W-1:0]     in_green,
	input  logic [PIX_W-1:0]     in_blue,
	input  logic                 q_full,
	output logic                 q_push,
	output pix_item_t            q_item
);

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	logic [SIDE_W-1:0] w_eff;
	logic [SIDE_W-1:0] h_eff;
	logic [SIDE_W-1:0] col_inc;
	logic [SIDE_W-1:0] row_inc;
	logic              last_col;
	logic              last_row;

	assign w_eff    = eff_side(width_q);
	assign h_eff    = eff_side(height_q);
	assign col_inc  = {1'b0, col_q} + SIDE_W'(1);
	assign row_inc  = {1'b0, row_q} + SIDE_W'(1);
	assign last_col = col_inc >= w_eff;
	assign last_row = row_inc >= h_eff;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.red          = in_red;
		q_item.green        = in_green;
		q_item.blue         = in_blue;
		q_item.chroma_valid = !col_q[0] && !last_col && !row_q[0] && !last_row;
		q_item.frame_end    = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CNT_W-1:0];
				end
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

endmodule

/* rtl/core/rgb2yuv_fifo.sv */
// short word queue between front and back end
module rgb2yuv_fifo import rgb2yuv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output pix_item_t head_item
);

	pix_item_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    count_q;

	assign full      = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty     = count_q == '0;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/rgb2yuv_back.sv */
// back end: luma, chroma products and saturation, with output register
module rgb2yuv_back import rgb2yuv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  pix_item_t        q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_luma,
	output logic             out_chroma_valid,
	output logic [PIX_W-1:0] out_u,
	output logic [PIX_W-1:0] out_v,
	output logic             out_frame_end
);

	logic              valid_s1;
	logic [PIX_W-1:0]  luma_s1;
	logic [PIX_W-1:0]  red_s1;
	logic [PIX_W-1:0]  blue_s1;
	logic              cv_s1;
	logic              fe_s1;

	logic              valid_s2;
	logic [PIX_W-1:0]  luma_s2;
	logic signed [15:0] prod_u_s2;
	logic signed [15:0] prod_v_s2;
	logic              cv_s2;
	logic              fe_s2;

	logic              out_valid_q;
	logic [PIX_W-1:0]  luma_q;
	logic              cv_q;
	logic [PIX_W-1:0]  u_q;
	logic [PIX_W-1:0]  v_q;
	logic              fe_q;

	logic              adv_out;
	logic              adv_s2;
	logic              adv_s1;
	logic [14:0]       luma_sum;
	logic signed [8:0] diff_u;
	logic signed [8:0] diff_v;

	assign adv_out = !out_valid_q || out_ready;
	assign adv_s2  = !valid_s2 || adv_out;
	assign adv_s1  = !valid_s1 || adv_s2;
	assign q_pop   = !q_empty && adv_s1;

	assign luma_sum = 15'(q_head.red) * K_R + 15'(q_head.green) * K_G
		+ 15'(q_head.blue) * K_B;
	assign diff_u = $signed({1'b0, blue_s1}) - $signed({1'b0, luma_s1});
	assign diff_v = $signed({1'b0, red_s1}) - $signed({1'b0, luma_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= q_pop;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			luma_s1 <= luma_sum[14:7];
			red_s1  <= q_head.red;
			blue_s1 <= q_head.blue;
			cv_s1   <= q_head.chroma_valid;
			fe_s1   <= q_head.frame_end;
		end
		if (adv_s2) begin
			luma_s2   <= luma_s1;
			prod_u_s2 <= K_U * {{7{diff_u[8]}}, diff_u};
			prod_v_s2 <= K_V * {{7{diff_v[8]}}, diff_v};
			cv_s2     <= cv_s1;
			fe_s2     <= fe_s1;
		end
		if (adv_out) begin
			luma_q <= luma_s2;
			cv_q   <= cv_s2;
			u_q    <= cv_s2 ? sat_chroma(prod_u_s2) : '0;
			v_q    <= cv_s2 ? sat_chroma(prod_v_s2) : '0;
			fe_q   <= fe_s2;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_luma         = luma_q;
	assign out_chroma_valid = cv_q;
	assign out_u            = u_q;
	assign out_v            = v_q;
	assign out_frame_end    = fe_q;

endmodule

/* rtl/core/rgb_to_yuv420_converter_unit.sv */
// top level of the rgb to yuv 4:2:0 converter
//
//  channel   dir  handshake      word
//  pix_in    in   valid/ready    red, green, blue
//  yuv_out   out  valid/ready    luma, chroma_valid, u_out, v_out, frame_end
//  cfg       in   cfg_we         cfg_index, cfg_wdata (width, height)
//
// one pixel per cycle sustained while yuv_out.ready stays high; a taken word is registered in
// turn at the queue write, luma stage, chroma product stage and output register
// arst_n clears counters, queue and pipeline valids; sizes reset to 640 x 480
// a stalled output fills the 4-deep queue before pix_in.ready drops
module rgb_to_yuv420_converter_unit import rgb2yuv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rgb2yuv_pix_if.sink          pix_in,
	rgb2yuv_yuv_if.source        yuv_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	pix_item_t push_item;
	pix_item_t head_item;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	rgb2yuv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_red    (pix_in.red),
		.in_green  (pix_in.green),
		.in_blue   (pix_in.blue),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	rgb2yuv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_item (head_item)
	);

	rgb2yuv_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_head           (head_item),
		.q_pop            (q_pop),
		.out_valid        (yuv_out.valid),
		.out_ready        (yuv_out.ready),
		.out_luma         (yuv_out.luma),
		.out_chroma_valid (yuv_out.chroma_valid),
		.out_u            (yuv_out.u_out),
		.out_v            (yuv_out.v_out),
		.out_frame_end    (yuv_out.frame_end)
	);

endmodule

/* rtl/core/rgb2yuv_checker.sv */
// port-level checks of the converter output, bound to the top level
module rgb2yuv_checker import rgb2yuv_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] luma,
	input logic             chroma_valid,
	input logic [PIX_W-1:0] u_out,
	input logic [PIX_W-1:0] v_out,
	input logic             frame_end
);

	// a stalled word stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled word keeps its contents
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(luma) && $stable(chroma_valid)
			&& $stable(u_out) && $stable(v_out) && $stable(frame_end))
		else $error("output word changed while stalled");

	// last pixel of a frame is never a chroma site
	a_end_no_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(chroma_valid && frame_end))
		else $error("chroma on last pixel of frame");

	// chroma fields are zero on luma-only pixels
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |-> u_out == '0 && v_out == '0)
		else $error("chroma fields set without chroma_valid");

endmodule

bind rgb_to_yuv420_converter_unit rgb2yuv_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (yuv_out.valid),
	.out_ready    (yuv_out.ready),
	.luma         (yuv_out.luma),
	.chroma_valid (yuv_out.chroma_valid),
	.u_out        (yuv_out.u_out),
	.v_out        (yuv_out.v_out),
	.frame_end    (yuv_out.frame_end)
);

/* tb/rgb_to_yuv420_converter_unit_tb.sv */
// testbench for the rgb to yuv 4:2:0 converter: random pixel words against a predicted result
module rgb_to_yuv420_converter_unit_tb;
	import rgb2yuv_pkg::*;

	localparam logic [23:0] PRIMARIES [6] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF
	};

	typedef struct {
		logic [PIX_W-1:0] luma;
		logic             chroma_valid;
		logic [PIX_W-1:0] u_out;
		logic [PIX_W-1:0] v_out;
		logic             frame_end;
	} yuv_word_t;

	class yuv420_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		int unsigned      column_pos;
		int unsigned      row_pos;
		yuv_word_t        pending_words[$];
		int               errors;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			column_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_WIDTH) begin
				width_reg = val;
			end else begin
				height_reg = val;
			end
		endfunction

		function int unsigned clamp_side(logic [CFG_W-1:0] val);
			if (val < 2) return 2;
			if (val > MAX_SIDE) return MAX_SIDE;
			return val;
		endfunction

		// floor shift, offset, saturate to a byte
		function logic [PIX_W-1:0] chroma_of(int k, int diff);
			int q;
			q = ((k * diff) >>> 7) + 128;
			if (q < 0) return 8'd0;
			if (q > 255) return 8'd255;
			return q[PIX_W-1:0];
		endfunction

		function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
				logic [PIX_W-1:0] b);
			yuv_word_t   w;
			int unsigned fw;
			int unsigned fh;
			int          y;
			bit          last_col;
			bit          last_row;
			fw = clamp_side(width_reg);
			fh = clamp_side(height_reg);
			y = (38 * int'(r) + 75 * int'(g) + 15 * int'(b)) >> 7;
			last_col = (column_pos + 1 >= fw);
			last_row = (row_pos + 1 >= fh);
			w.luma = y[PIX_W-1:0];
			w.chroma_valid = !column_pos[0] && !last_col && !row_pos[0] && !last_row;
			w.u_out = w.chroma_valid ? chroma_of(71, int'(b) - y) : 8'd0;
			w.v_out = w.chroma_valid ? chroma_of(91, int'(r) - y) : 8'd0;
			w.frame_end = last_col && last_row;
			pending_words.push_back(w);
			if (last_col) begin
				column_pos = 0;
				row_pos = last_row ? 0 : row_pos + 1;
			end else begin
				column_pos = column_pos + 1;
			end
		endfunction

		function void check_word(logic [PIX_W-1:0] luma, logic chroma_valid,
				logic [PIX_W-1:0] u_out, logic [PIX_W-1:0] v_out, logic frame_end);
			yuv_word_t w;
			if (pending_words.size() == 0) begin
				$error("yuv word with none pending: luma %0d", luma);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			if (luma !== w.luma) begin
				$error("luma expected %0d actual %0d", w.luma, luma);
				errors++;
			end
			if (chroma_valid !== w.chroma_valid) begin
				$error("chroma_valid expected %0d actual %0d", w.chroma_valid, chroma_valid);
				errors++;
			end
			if (u_out !== w.u_out) begin
				$error("u_out expected %0d actual %0d", w.u_out, u_out);
				errors++;
			end
			if (v_out !== w.v_out) begin
				$error("v_out expected %0d actual %0d", w.v_out, v_out);
				errors++;
			end
			if (frame_end !== w.frame_end) begin
				$error("frame_end expected %0d actual %0d", w.frame_end, frame_end);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	int                   src_idle_pct;
	int                   snk_stall_pct;
	logic                 hold_request;
	int                   hold_count;
	yuv420_scoreboard     sb;

	rgb2yuv_pix_if pix_if();
	rgb2yuv_yuv_if yuv_if();

	rgb_to_yuv420_converter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_if),
		.yuv_out   (yuv_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// receiver: random stalls, plus one long hold-off
	always @(negedge clk) begin
		if (hold_request && hold_count < 48) begin
			yuv_if.ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			yuv_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && yuv_if.valid && yuv_if.ready) begin
			sb.check_word(yuv_if.luma, yuv_if.chroma_valid, yuv_if.u_out, yuv_if.v_out,
				yuv_if.frame_end);
		end
	end

	function automatic logic [PIX_W-1:0] rand_component();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return PIX_W'($urandom_range(255));
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.red <= r;
		pix_if.green <= g;
		pix_if.blue <= b;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		sb.note_pixel(r, g, b);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (sb.pending_words.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_wdata <= w;
		sb.write_size(REG_WIDTH, w);
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_wdata <= h;
		sb.write_size(REG_HEIGHT, h);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int src_pct, input int snk_pct, input int n_words, input bit hold);
		wait_idle();
		write_sizes(w, h);
		src_idle_pct <= src_pct;
		snk_stall_pct <= snk_pct;
		if (hold) begin
			hold_request <= 1'b1;
		end
		@(negedge clk);
		for (int i = 0; i < n_words; i++) begin
			send_pixel(rand_component(), rand_component(), rand_component());
		end
		pix_if.valid <= 1'b0;
	endtask

	initial begin
		timeout_guard();
	end

	task automatic timeout_guard();
		#1000000;
		$display("rgb_to_yuv420_converter_unit regression: fail");
		$finish;
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_wdata = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_request = 1'b0;
		hold_count = 0;
		pix_if.valid = 1'b0;
		pix_if.red = '0;
		pix_if.green = '0;
		pix_if.blue = '0;
		yuv_if.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sizes below the minimum: each color fills a whole 2x2 frame
		write_sizes(13'd0, 13'd1);
		for (int c = 0; c < 6; c++) begin
			for (int k = 0; k < 4; k++) begin
				send_pixel(PRIMARIES[c][23:16], PRIMARIES[c][15:8], PRIMARIES[c][7:0]);
			end
		end
		pix_if.valid <= 1'b0;

		run_phase(13'd3, 13'd3, 0, 0, 60, 1'b0);
		run_phase(13'd5, 13'd2, 58, 0, 60, 1'b0);
		// widest row, left mid-row so the next sizes shrink under the counters
		run_phase(13'd8191, 13'd2, 0, 58, 50, 1'b0);
		run_phase(13'd2, 13'd4, 32, 32, 50, 1'b0);
		run_phase(13'd4097, 13'd4096, 0, 0, 40, 1'b0);
		run_phase(13'd6, 13'd4, 0, 0, 70, 1'b1);
		run_phase(13'd1, 13'd3, 58, 0, 40, 1'b0);
		run_phase(13'd4, 13'd2, 0, 58, 40, 1'b0);

		wait_idle();
		repeat (4) @(negedge clk);
		if (sb.errors == 0) begin
			$display("rgb_to_yuv420_converter_unit regression: pass");
		end else begin
			$display("rgb_to_yuv420_converter_unit regression: fail");
		end
		$finish;
	end

endmodule
